// File: rtl/core/stream_search_replace_assert.svh
// assertion macros for the stream search and replace core
// used by modules that carry a clk and an active-low arst_n in scope
`ifndef STREAM_SEARCH_REPLACE_ASSERT_SVH
`define STREAM_SEARCH_REPLACE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SSR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ssr_pkg.sv
// shared types and constants for the stream search and replace core
// no dependencies; imported by every module of the core
package ssr_pkg;

	localparam int MAX_LEN_DEF = 8;   // default longest pattern
	localparam int LIT_MAX     = 8;   // literal slots in one burst, upper bound of MAX_LEN
	localparam int REP_MAX     = 8;   // longest replacement
	localparam int CNT_W       = 32;

	typedef enum logic [1:0] {
		CFG_PATTERN = 2'd0,
		CFG_PLEN    = 2'd1,
		CFG_REPL    = 2'd2,
		CFG_RLEN    = 2'd3
	} cfg_idx_t;

	// configuration after range clamping
	typedef struct packed {
		logic [63:0] pattern;
		logic [3:0]  plen;
		logic [63:0] repl;
		logic [3:0]  rlen;
	} cfg_t;

	// everything one input byte yields, handed from matcher to emitter
	typedef struct packed {
		logic [LIT_MAX-1:0][7:0] lit;
		logic [3:0]              lit_cnt;
		logic [3:0]              rep_cnt;
		logic                    fin;
		logic [4:0]              tot;
		logic [CNT_W-1:0]        cnt_old;
		logic [CNT_W-1:0]        cnt_new;
	} burst_t;

endpackage

// File: rtl/core/ssr_window.sv
// pending window, prefix matcher and replacement counter
// depends on ssr_pkg
module ssr_window import ssr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       pat_write,
	input  logic       go,
	input  logic [7:0] byte_s1,
	input  logic       final_s1,
	output burst_t     plan,
	output logic       has_results
);

	localparam int WIN_D = (MAX_LEN > 1) ? MAX_LEN - 1 : 1;
	localparam int PC_W  = $clog2(MAX_LEN + 1);

	logic [7:0]       win_q [WIN_D];
	logic [7:0]       win_n [WIN_D];
	logic [PC_W-1:0]  pc_q, pc_n, pc_inc, jstar, nstar, lit_n;
	logic             stale_q;
	logic [CNT_W-1:0] total_q, total_new;
	logic [7:0]       t [MAX_LEN];
	logic [MAX_LEN-1:0] cand;
	logic             hit, match;
	logic [4:0]       tot_raw;

	// text under test: pending bytes then the new byte
	genvar k;
	generate
		for (k = 0; k < MAX_LEN; k++) begin : g_text
			if (k < MAX_LEN - 1) begin : g_win
				assign t[k] = (PC_W'(k) < pc_q) ? win_q[k] :
					((PC_W'(k) == pc_q) ? byte_s1 : 8'h00);
			end else begin : g_tail
				assign t[k] = (PC_W'(k) == pc_q) ? byte_s1 : 8'h00;
			end
		end
	endgenerate

	assign pc_inc = pc_q + PC_W'(1);

	// candidate start offsets; a stale window only tries the new byte
	always_comb begin
		for (int j = 0; j < MAX_LEN; j++) begin
			cand[j] = (j <= int'(pc_q)) && (!stale_q || j == int'(pc_q));
			for (int i = 0; i < MAX_LEN; i++) begin
				if (i + j < MAX_LEN) begin
					if (i + j <= int'(pc_q) && t[i+j] != cfg.pattern[8*i +: 8])
						cand[j] = 1'b0;
				end
			end
		end
	end

	// leftmost surviving start
	always_comb begin
		hit   = 1'b0;
		jstar = pc_inc;
		for (int j = MAX_LEN - 1; j >= 0; j--) begin
			if (cand[j]) begin
				hit   = 1'b1;
				jstar = PC_W'(j);
			end
		end
	end

	assign nstar = pc_inc - jstar;
	assign match = hit && (int'(nstar) == int'(cfg.plen));
	assign lit_n = (!match && final_s1) ? pc_inc : jstar;

	assign total_new = (match && total_q != {CNT_W{1'b1}}) ? total_q + CNT_W'(1) : total_q;

	always_comb begin
		plan = '0;
		for (int i = 0; i < LIT_MAX; i++) begin
			if (i < MAX_LEN)
				plan.lit[i] = t[i];
		end
		plan.lit_cnt = 4'(lit_n);
		plan.rep_cnt = match ? cfg.rlen : 4'd0;
		plan.fin     = final_s1;
		tot_raw      = 5'(lit_n) + 5'(plan.rep_cnt);
		// a final byte with nothing to show still ends the stream with a bare marker
		plan.tot     = (final_s1 && tot_raw == 5'd0) ? 5'd1 : tot_raw;
		plan.cnt_old = total_q;
		plan.cnt_new = total_new;
		has_results  = (tot_raw != 5'd0) || final_s1;
	end

	// surviving bytes slide down to the front of the window
	always_comb begin
		for (int i = 0; i < WIN_D; i++) begin
			win_n[i] = 8'h00;
			for (int j = 0; j < MAX_LEN; j++) begin
				if (i + j < MAX_LEN) begin
					if (jstar == PC_W'(j))
						win_n[i] = t[i+j];
				end
			end
		end
	end

	assign pc_n = (match || final_s1) ? PC_W'(0) : nstar;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			stale_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (pat_write)
				stale_q <= 1'b1;
			else if (go)
				stale_q <= 1'b0;
			if (go) begin
				pc_q    <= pc_n;
				total_q <= final_s1 ? '0 : total_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go)
			win_q <= win_n;
	end

endmodule

// File: rtl/core/ssr_emit.sv
// burst register and output register: plays out one burst a result per cycle while out_ready allows
// depends on ssr_pkg and stream_search_replace_assert.svh
`include "stream_search_replace_assert.svh"

module ssr_emit import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  burst_t           plan,
	input  logic             load,
	input  logic [63:0]      repl,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_present,
	output logic             run_last,
	output logic             stream_done,
	output logic [CNT_W-1:0] match_count
);

	logic             valid_s2;
	burst_t           b_s2;
	logic [4:0]       pos_q, ridx, lit_end, rep_end;
	logic             emit_go, last;
	logic [7:0]       sel_byte;
	logic             sel_present;
	logic [CNT_W-1:0] sel_cnt;
	logic             out_valid_q, byte_present_q, run_last_q, stream_done_q;
	logic [7:0]       out_byte_q;
	logic [CNT_W-1:0] match_count_q;

	assign emit_go = valid_s2 && (!out_valid_q || out_ready);
	assign last    = (pos_q == b_s2.tot - 5'd1);
	assign free    = !valid_s2 || (emit_go && last);

	assign lit_end = 5'(b_s2.lit_cnt);
	assign rep_end = lit_end + 5'(b_s2.rep_cnt);
	assign ridx    = pos_q - lit_end;

	always_comb begin
		sel_byte    = 8'h00;
		sel_present = 1'b0;
		sel_cnt     = b_s2.cnt_new;
		if (pos_q < lit_end) begin
			sel_present = 1'b1;
			sel_cnt     = b_s2.cnt_old;
			for (int k = 0; k < LIT_MAX; k++) begin
				if (pos_q == 5'(k))
					sel_byte = b_s2.lit[k];
			end
		end else if (pos_q < rep_end) begin
			sel_present = 1'b1;
			for (int k = 0; k < REP_MAX; k++) begin
				if (ridx == 5'(k))
					sel_byte = repl[8*k +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
				pos_q    <= '0;
			end else if (emit_go && last) begin
				valid_s2 <= 1'b0;
			end else if (emit_go) begin
				pos_q <= pos_q + 5'd1;
			end
			if (emit_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			b_s2 <= plan;
		if (emit_go) begin
			out_byte_q     <= sel_byte;
			byte_present_q <= sel_present;
			run_last_q     <= last;
			stream_done_q  <= last && b_s2.fin;
			match_count_q  <= sel_cnt;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign byte_present = byte_present_q;
	assign run_last     = run_last_q;
	assign stream_done  = stream_done_q;
	assign match_count  = match_count_q;

	`SSR_ASSERT_SAME(a_pos_in_range, valid_s2, pos_q < b_s2.tot, "burst position past its end")
	`SSR_ASSERT_SAME(a_load_when_free, load, free, "burst loaded while previous one still playing")
	`SSR_ASSERT_SAME(a_burst_nonempty, load, plan.tot != 5'd0, "empty burst loaded")
	`SSR_ASSERT_NEXT(a_last_frees, emit_go && last && !load, !valid_s2, "burst kept after last result")

endmodule

// File: rtl/core/stream_search_replace.sv
// top level of the stream search and replace core
// depends on ssr_pkg, ssr_window and ssr_emit
// the first result of an accepted byte goes through the input, burst and output registers
// throughput: one byte per cycle while out_ready is high and each yields at most one result;
//   a byte with more than one result (stale flush, mismatch run, replacement) stalls input
// reset: control, counters and config go to defaults; data and window bytes are not cleared
module stream_search_replace import ssr_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration writes
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_index,
	input  logic [63:0]      cfg_data,
	// input stream
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             final_byte,
	// result stream
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_present,
	output logic             run_last,
	output logic             stream_done,
	output logic [CNT_W-1:0] match_count
);

	// configuration registers, raw as written
	logic [63:0] pattern_q, repl_q;
	logic [3:0]  plen_q, rlen_q;
	cfg_t        cfg;
	logic        pat_write;
	cfg_idx_t    widx;

	// input register stage
	logic        valid_s1, final_s1;
	logic [7:0]  byte_s1;

	// handoff between matcher and emitter
	burst_t      plan;
	logic        has_results, emit_free, proc_go;

	assign widx      = cfg_idx_t'(cfg_index);
	// any pattern change turns the pending bytes into plain text
	assign pat_write = cfg_wr_en && (widx == CFG_PATTERN || widx == CFG_PLEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= 4'd1;
			repl_q    <= '0;
			rlen_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (widx)
				CFG_PATTERN: pattern_q <= cfg_data;
				CFG_PLEN:    plen_q    <= cfg_data[3:0];
				CFG_REPL:    repl_q    <= cfg_data;
				CFG_RLEN:    rlen_q    <= cfg_data[3:0];
				default:     pattern_q <= pattern_q;
			endcase
		end
	end

	// clamp lengths into their legal ranges
	always_comb begin
		cfg.pattern = pattern_q;
		cfg.repl    = repl_q;
		if (plen_q == 4'd0)
			cfg.plen = 4'd1;
		else if (int'(plen_q) > MAX_LEN)
			cfg.plen = 4'(MAX_LEN);
		else
			cfg.plen = plen_q;
		cfg.rlen = (int'(rlen_q) > REP_MAX) ? 4'(REP_MAX) : rlen_q;
	end

	// a byte that yields nothing can retire even while the emitter is busy
	assign proc_go  = valid_s1 && (emit_free || !has_results);
	assign in_ready = !valid_s1 || proc_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (proc_go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			final_s1 <= final_byte;
		end
	end

	// window state, match search and counter update
	ssr_window #(
		.MAX_LEN (MAX_LEN)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pat_write   (pat_write),
		.go          (proc_go),
		.byte_s1     (byte_s1),
		.final_s1    (final_s1),
		.plan        (plan),
		.has_results (has_results)
	);

	// result sequencing and the output transaction register
	ssr_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.plan         (plan),
		.load         (proc_go && has_results),
		.repl         (cfg.repl),
		.free         (emit_free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.run_last     (run_last),
		.stream_done  (stream_done),
		.match_count  (match_count)
	);

endmodule
